[src/token_expiry_table_macros.svh]
// ----------------------------------------------------------------------------
// Token expiry table assertion macros
// Shared property wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TOKEN_EXPIRY_TABLE_MACROS_SVH
`define TOKEN_EXPIRY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TET_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/tet_pkg.sv]
// ----------------------------------------------------------------------------
// Token expiry table package
// Table size, derived widths, operation and status codes, state encoding.
// ----------------------------------------------------------------------------
package tet_pkg;

    // Number of table entries and the widths that follow from it.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 31;
    localparam int EXP_W   = 32;
    localparam int BIRTH_W = 32;
    localparam int LIVE_W  = 5;
    localparam int LIVE_MAX = 31;

    // Configuration register index (one register, selected by paddr[2]).
    localparam logic REG_TTL = 1'b0;
    localparam logic [TIME_W-1:0] TTL_RESET = 31'd5;

    typedef enum logic [1:0] {
        OP_GENERATE = 2'd0,
        OP_RENEW    = 2'd1,
        OP_COUNT    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } state_t;

    // One memory word per table entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [EXP_W-1:0]   expiry;
        logic [BIRTH_W-1:0] birth;
    } entry_t;

endpackage

[src/token_expiry_table.sv]
// ----------------------------------------------------------------------------
// Token expiry table
// A bounded table of keyed tokens with expiry times. Each operation frees
// expired entries, then generates, renews or only counts, and returns the
// number of live entries with a status.
// ----------------------------------------------------------------------------
// An accepted word is swept over every entry before the next word can be
// accepted: the entries sit in one memory with a single read port, so the
// sweep reads one entry per cycle and evaluates it from the registered read
// data, then a write-back state also loads the result register, and the
// table returns to idle. A result waiting at the output does not block
// the next word from being accepted; it only holds the write-back of the
// following word until the result is taken. There is no clearing pass after
// reset; validity is kept in flip-flops. time_to_live is written through the
// APB port at byte address 0 and must only be changed while the table is idle.
// ----------------------------------------------------------------------------
module token_expiry_table
    import tet_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Operation input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [KEY_W-1:0]    s_token_key,
    input  logic [TIME_W-1:0]   s_current_time,

    // Result output
    output logic                m_valid,
    input  logic                m_ready,
    output logic [LIVE_W-1:0]   m_live_count,
    output logic [1:0]          m_status
);

    // Control registers.
    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [BIRTH_W-1:0]   nbo_reg, nbo_next;
    logic [TIME_W-1:0]    ttl_reg, ttl_next;
    logic [IDX_W:0]       issue_cnt_reg, issue_cnt_next;
    logic                 proc_vld_reg, proc_vld_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 free_found_reg, free_found_next;
    logic                 best_found_reg, best_found_next;

    // Operation and scan payload registers.
    logic [1:0]           op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [IDX_W-1:0]     proc_idx_reg, proc_idx_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [BIRTH_W-1:0]   best_age_reg, best_age_next;
    logic [BIRTH_W-1:0]   best_birth_reg, best_birth_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LIVE_W-1:0]    live_reg, live_next;
    logic [1:0]           status_reg, status_next;

    // Entry memory.
    entry_t               mem [ENTRIES];
    entry_t               rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;

    // Combinational helpers.
    logic                 cfg_wr;
    logic [EXP_W-1:0]     new_expiry;
    logic                 entry_live;
    logic [BIRTH_W-1:0]   entry_age;
    logic                 out_free;
    logic [CNT_W-1:0]     cnt_final;

    // APB register access; pready is always high.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TTL) ? {1'b0, ttl_reg} : 32'd0;

    always_comb begin
        ttl_next = ttl_reg;
        if (cfg_wr && paddr[2] == REG_TTL) begin
            ttl_next = pwdata[TIME_W-1:0];
        end
    end

    // Handshake outputs.
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_live_count = live_reg;
    assign m_status     = status_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // Expiry given to a generated or renewed entry; never overflows 32 bits.
    assign new_expiry = {1'b0, now_reg} + {1'b0, ttl_reg};

    // Entry under evaluation: live if valid and expiring after now.
    assign entry_live = valid_reg[proc_idx_reg] &&
                        (rd_data_reg.expiry > {1'b0, now_reg});
    assign entry_age  = nbo_reg - rd_data_reg.birth;

    // Read address follows the issue counter.
    assign rd_addr = issue_cnt_reg[IDX_W-1:0];

    // Next state, scan accumulation, write-back and result.
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        nbo_next        = nbo_reg;
        issue_cnt_next  = issue_cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        m_valid_next    = m_valid_reg;
        free_found_next = free_found_reg;
        best_found_next = best_found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        free_idx_next   = free_idx_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_birth_next = best_birth_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx_reg;
        mem_wdata       = '{key: key_reg, expiry: new_expiry, birth: nbo_reg};
        cnt_final       = cnt_reg;

        // The result register empties when the word is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    key_next        = s_token_key;
                    now_next        = s_current_time;
                    issue_cnt_next  = '0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = S_SWEEP;
                end
            end

            S_SWEEP: begin
                // Issue one read per cycle.
                if (issue_cnt_reg < (IDX_W+1)'(ENTRIES)) begin
                    proc_vld_next  = 1'b1;
                    proc_idx_next  = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end

                // Evaluate the entry whose data has arrived.
                if (proc_vld_reg) begin
                    if (!entry_live) begin
                        valid_next[proc_idx_reg] = 1'b0;
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        if (rd_data_reg.key == key_reg &&
                            (!best_found_reg || entry_age > best_age_reg)) begin
                            best_found_next = 1'b1;
                            best_idx_next   = proc_idx_reg;
                            best_age_next   = entry_age;
                            best_birth_next = rd_data_reg.birth;
                        end
                    end
                    if (proc_idx_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                // Write back and load the result once the output is free.
                if (out_free) begin
                    status_next = ST_DONE;
                    if (op_reg == OP_GENERATE) begin
                        if (free_found_reg) begin
                            mem_we                  = 1'b1;
                            mem_waddr               = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            nbo_next                = nbo_reg + 1'b1;
                            if (ttl_reg != '0) begin
                                cnt_final = cnt_reg + 1'b1;
                            end
                        end else begin
                            status_next = ST_FULL;
                        end
                    end else if (op_reg == OP_RENEW) begin
                        if (best_found_reg) begin
                            mem_we    = 1'b1;
                            mem_waddr = best_idx_reg;
                            mem_wdata = '{key: key_reg, expiry: new_expiry,
                                          birth: best_birth_reg};
                            if (ttl_reg == '0) begin
                                cnt_final = cnt_reg - 1'b1;
                            end
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    // Saturate the count to the output width.
                    if (32'(cnt_final) > 32'(LIVE_MAX)) begin
                        live_next = LIVE_W'(LIVE_MAX);
                    end else begin
                        live_next = LIVE_W'(cnt_final);
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            nbo_reg        <= '0;
            ttl_reg        <= TTL_RESET;
            issue_cnt_reg  <= '0;
            proc_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            nbo_reg        <= nbo_next;
            ttl_reg        <= ttl_next;
            issue_cnt_reg  <= issue_cnt_next;
            proc_vld_reg   <= proc_vld_next;
            m_valid_reg    <= m_valid_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        proc_idx_reg   <= proc_idx_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_birth_reg <= best_birth_next;
        cnt_reg        <= cnt_next;
        live_reg       <= live_next;
        status_reg     <= status_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Assertions.
`include "token_expiry_table_macros.svh"

    `TET_ASSERT_NEXT(a_accept_starts_sweep, s_valid && s_ready, state_reg == S_SWEEP && issue_cnt_reg == '0, "accepted word did not start a sweep at entry zero")
    `TET_ASSERT_SAME(a_full_means_all_valid, state_reg == S_FINISH && !free_found_reg, &valid_reg, "no free entry found although a valid bit is clear")
    `TET_ASSERT_SAME(a_count_bounded, m_valid, 32'(m_live_count) <= 32'(ENTRIES), "live count exceeds table size")
    `TET_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_live_count) && $stable(m_status), "result word changed while stalled")

endmodule

[sim/tb_token_expiry_table.sv]
// ----------------------------------------------------------------------------
// Token expiry table testbench
// Sends generate, renew and count words with random idle and stall bursts.
// The time_to_live register is changed between phases over the APB port.
// A scoreboard tracks its own copy of the table and checks every result
// word, in order, against the expected live count and status.
// ----------------------------------------------------------------------------
module tb_token_expiry_table;
    import tet_pkg::*;

    localparam logic [1:0]        OP_UNUSED = 2'd3;
    localparam logic [2:0]        TTL_ADDR  = {REG_TTL, 2'b00};
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } token_op_t;

    typedef struct packed {
        logic [LIVE_W-1:0] live;
        logic [1:0]        status;
    } op_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode       = '0;
    logic [KEY_W-1:0]  s_token_key    = '0;
    logic [TIME_W-1:0] s_current_time = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [LIVE_W-1:0] m_live_count;
    logic [1:0]        m_status;

    // Words waiting to be sent and results waiting to be seen.
    token_op_t  pending_ops[$];
    op_result_t expected_results[$];

    // Scoreboard copy of the table and of the lifetime register.
    logic              tbl_valid  [ENTRIES];
    logic [KEY_W-1:0]  tbl_key    [ENTRIES];
    logic [EXP_W-1:0]  tbl_expiry [ENTRIES];
    logic [BIRTH_W-1:0] tbl_birth [ENTRIES];
    logic [BIRTH_W-1:0] birth_counter;
    logic [TIME_W-1:0] ttl_cfg = TTL_RESET;

    int          mismatch_count = 0;
    int          stall_odds     = 0;
    int          send_gap       = 0;
    int          stall_left     = 0;
    logic        word_taken     = 1'b0;
    logic [TIME_W-1:0] now_t    = '0;

    token_expiry_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_token_key    (s_token_key),
        .s_current_time (s_current_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_live_count   (m_live_count),
        .m_status       (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Applies one operation to the scoreboard table and returns its result.
    function automatic op_result_t apply_token_op(input logic [1:0] op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [TIME_W-1:0] stamp);
        logic [EXP_W-1:0]   now_wide;
        logic [EXP_W-1:0]   new_expiry;
        logic [BIRTH_W-1:0] age;
        logic [BIRTH_W-1:0] best_age;
        int                 slot;
        int                 live;
        op_result_t         res;
        now_wide   = {1'b0, stamp};
        new_expiry = now_wide + {1'b0, ttl_cfg};
        res.status = ST_DONE;
        slot       = -1;
        best_age   = '0;
        live       = 0;

        // Expired entries go first, whatever the operation.
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_expiry[i] <= now_wide) begin
                tbl_valid[i] = 1'b0;
            end
        end

        case (op)
            OP_GENERATE: begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_valid[slot]  = 1'b1;
                    tbl_key[slot]    = key;
                    tbl_expiry[slot] = new_expiry;
                    tbl_birth[slot]  = birth_counter;
                    birth_counter    = birth_counter + 1'b1;
                end
            end
            OP_RENEW: begin
                // The oldest matching entry wins; on equal age the lowest index.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_key[i] == key) begin
                        age = birth_counter - tbl_birth[i];
                        if (slot < 0 || age > best_age) begin
                            slot     = i;
                            best_age = age;
                        end
                    end
                end
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    tbl_expiry[slot] = new_expiry;
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_expiry[i] > now_wide) begin
                live++;
            end
        end
        res.live = (live > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live);
        return res;
    endfunction

    // Monitor: records accepted words and checks result words at the rising edge.
    always @(posedge aclk) begin
        op_result_t want;
        word_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(apply_token_op(s_opcode, s_token_key,
                                                      s_current_time));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result word: live_count %0d status %0d",
                             m_live_count, m_status);
                end
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_live_count !== want.live || m_status !== want.status) begin
                    if (mismatch_count < 10) begin
                        $display({"result mismatch: live_count %0d (expected %0d), ",
                                  "status %0d (expected %0d)"},
                                 m_live_count, want.live, m_status, want.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Driver: presents pending words and random idle and stall bursts.
    always @(negedge aclk) begin
        token_op_t w;
        if (!(s_valid && !word_taken)) begin
            if (send_gap > 0 && stall_odds > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_ops.size() > 0 && stall_odds > 0 &&
                         $urandom_range(0, stall_odds - 1) == 0) begin
                send_gap = $urandom_range(1, 14) - 1;
                s_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                w = pending_ops.pop_front();
                s_valid        <= 1'b1;
                s_opcode       <= w.op;
                s_token_key    <= w.key;
                s_current_time <= w.stamp;
            end else begin
                s_valid <= 1'b0;
            end
        end

        if (stall_left > 0 && stall_odds > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_odds > 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                            input logic [TIME_W-1:0] stamp);
        token_op_t w;
        w.op    = op;
        w.key   = key;
        w.stamp = stamp;
        pending_ops.push_back(w);
    endtask

    // Holds off until every word is sent and every result has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the lifetime register, then reads it back.
    task automatic write_ttl(input logic [TIME_W-1:0] value);
        wait_drained();
        ttl_cfg = value;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TTL_ADDR;
        pwdata  <= {1'b0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        if (prdata[TIME_W-1:0] !== value) begin
            if (mismatch_count < 10) begin
                $display("time_to_live read back %0d (expected %0d)",
                         prdata[TIME_W-1:0], value);
            end
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic: mostly keys from a small pool so renews find matches,
    // time creeping forward, and now and then a step back in time.
    task automatic run_traffic(input int count, input int step_max);
        logic [KEY_W-1:0] key_pool [6];
        logic [TIME_W:0]  later;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        int               pick;
        int               back;
        foreach (key_pool[k]) begin
            key_pool[k] = $urandom();
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op = OP_GENERATE;
            end else if (pick < 80) begin
                op = OP_RENEW;
            end else if (pick < 95) begin
                op = OP_COUNT;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(0, 99) < 85) begin
                key = key_pool[$urandom_range(0, 5)];
            end else begin
                key = $urandom();
            end
            if ($urandom_range(0, 99) < 3) begin
                back = $urandom_range(0, 20);
                if (now_t >= back) begin
                    now_t = now_t - TIME_W'(back);
                end
            end else begin
                later = {1'b0, now_t} + $urandom_range(0, step_max);
                now_t = later[TIME_W] ? TIME_MAX : later[TIME_W-1:0];
            end
            queue_op(op, key, now_t);
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
        end
        birth_counter = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset lifetime: empty table, duplicate keys,
        // oldest-match renew, the unused opcode, expiry and time going back.
        stall_odds = 4;
        queue_op(OP_COUNT,    32'h0000_0000, 31'd0);
        queue_op(OP_RENEW,    32'h0000_0000, 31'd0);
        queue_op(OP_GENERATE, 32'h0000_0000, 31'd0);
        queue_op(OP_GENERATE, 32'hFFFF_FFFF, 31'd1);
        queue_op(OP_GENERATE, 32'h0000_0000, 31'd2);
        queue_op(OP_RENEW,    32'h0000_0000, 31'd3);
        queue_op(OP_UNUSED,   32'h0000_0000, 31'd4);
        queue_op(OP_COUNT,    32'hFFFF_FFFF, 31'd5);
        queue_op(OP_COUNT,    32'h1234_5678, 31'd6);
        queue_op(OP_GENERATE, 32'hA5A5_A5A5, 31'd6);
        queue_op(OP_COUNT,    32'h0000_0000, 31'd2);
        queue_op(OP_RENEW,    32'hFFFF_FFFF, 31'd7);

        // A zero lifetime: new and renewed entries are born already expired.
        write_ttl('0);
        queue_op(OP_GENERATE, 32'h0000_0001, 31'd10);
        queue_op(OP_COUNT,    32'h0000_0001, 31'd10);
        queue_op(OP_RENEW,    32'hA5A5_A5A5, 31'd10);
        queue_op(OP_RENEW,    32'h0000_0001, 31'd11);

        // Shortest nonzero lifetime, then the time field at its top value.
        write_ttl(31'd1);
        queue_op(OP_GENERATE, 32'h5A5A_5A5A, 31'd12);
        queue_op(OP_COUNT,    32'h0000_0000, 31'd12);
        queue_op(OP_GENERATE, 32'h5A5A_5A5A, TIME_MAX);
        queue_op(OP_RENEW,    32'h5A5A_5A5A, TIME_MAX);
        queue_op(OP_COUNT,    32'h0000_0000, TIME_MAX);
        queue_op(OP_GENERATE, 32'h0F0F_0F0F, 31'd20);

        // Random phases over a range of lifetimes and time steps.
        now_t = 31'd30;
        run_traffic(150, 1);
        write_ttl(31'd3);
        stall_odds = 6;
        run_traffic(200, 2);
        write_ttl(31'd1000);
        stall_odds = 3;
        run_traffic(250, 4);
        write_ttl(31'd200);
        stall_odds = 5;
        run_traffic(200, 60);
        write_ttl(31'd20);
        stall_odds = 4;
        now_t = 31'h7FFF_F000;
        run_traffic(250, 3);

        // Final stretch without idling; the longest lifetime fills the table.
        write_ttl(31'd8);
        stall_odds = 0;
        run_traffic(250, 2);
        write_ttl(TIME_MAX);
        run_traffic(100, 1);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/tet_pkg.sv
src/token_expiry_table.sv
sim/tb_token_expiry_table.sv
